// ===== rtl/u2c_pkg.sv =====
// Shared types and constants for the epoch-seconds to calendar converter.
// No dependencies; every module of the block imports this package.
package u2c_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECIP,
      ST_BACK,
      ST_REM,
      ST_YEAR,
      ST_MONTH,
      ST_LOAD
   } state_type;

   // Which remainder the division passes are producing
   typedef enum logic [1:0] {
      STG_SEC,
      STG_MIN,
      STG_HOUR,
      STG_WDAY
   } stage_type;

   // Shared unit operations
   typedef enum logic {
      ALU_MUL,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic        ge;
      logic [63:0] val;
   } alu_res_type;

   localparam int unsigned SEC_PER_MIN  = 60;
   localparam int unsigned MIN_PER_HOUR = 60;
   localparam int unsigned HOUR_PER_DAY = 24;
   localparam int unsigned DAY_PER_WEEK = 7;

   // Reciprocals: x / 15 = (x * RECIP_15) >> 35 and x / 3 = (x * RECIP_3) >> 33 for any
   // 32-bit x; x / 7 = (x * RECIP_7) >> 32 for x below 2^30
   localparam logic [31:0] RECIP_15 = 32'h8888_8889;
   localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP_7  = 32'h2492_4925;

   // Epoch day is a Thursday
   localparam logic [15:0] EPOCH_WDAY_OFS = 16'd4;

   localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
   localparam logic [6:0]  EPOCH_YEAR_100 = 7'd70;
   localparam logic [8:0]  EPOCH_YEAR_400 = 9'd370;
   localparam logic [15:0] DAYS_LEAP_YEAR = 16'd366;
   localparam logic [15:0] DAYS_YEAR      = 16'd365;
   localparam logic [3:0]  MONTH_LAST     = 4'd11;

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/u2c_alu.sv =====
// Shared arithmetic unit: one 32 x 32 multiply or one compare-and-subtract.
// Depends on u2c_pkg.
module u2c_alu import u2c_pkg::*; (
   input  alu_op_type  op,
   input  logic [31:0] opa,
   input  logic [31:0] opb,
   output alu_res_type res
);

   logic [63:0] prod;
   logic [32:0] delta;

   always_comb begin
      prod    = {32'd0, opa} * {32'd0, opb};
      delta   = {1'b0, opa} - {1'b0, opb};
      res.ge  = ~delta[32];
      res.val = (op == ALU_MUL) ? prod : {32'd0, delta[31:0]};
   end

endmodule

// ===== rtl/unix_time_to_calendar.sv =====
// Top level of the epoch-seconds to Gregorian date and time converter.
// Depends on u2c_pkg and u2c_alu.
//
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_stall | req_epoch_seconds (32b)
//   rsp_    | out       | rsp_valid/rsp_stall | sec, min, hour, weekday, year, month, day
//
// One word at a time: a new word is accepted only in the idle state, after the last
// one has left the load state. The single shared unit sets the pace: three passes
// per division (reciprocal multiply, multiply back, subtract) for four divisions,
// then one pass per whole year since 1970 and one per month.
// Reset clears the sequencer and rsp_valid only.
// A stalled result holds in the output register while the next word is accepted;
// a finished word waits in the load state until the output register frees up.
module unix_time_to_calendar import u2c_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [2:0]  rsp_weekday,
   output logic [11:0] rsp_year_number,
   output logic [3:0]  rsp_month_number,
   output logic [4:0]  rsp_day_of_month
);

   state_type   state_ff, state_in;
   stage_type   stg_ff, stg_in;

   // working registers
   logic [31:0] num_ff, num_in;     // dividend of the current division
   logic [31:0] quo_ff, quo_in;     // quotient of the current division
   logic [63:0] prod_ff, prod_in;   // last product of the shared unit
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hr_ff, hr_in;
   logic [2:0]  wd_ff, wd_in;
   logic [15:0] days_ff, days_in;
   logic [11:0] year_ff, year_in;
   logic [6:0]  ym100_ff, ym100_in; // year mod 100, tracked alongside year
   logic [8:0]  ym400_ff, ym400_in; // year mod 400
   logic [3:0]  mon_ff, mon_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [5:0]  out_sec_ff;
   logic [5:0]  out_min_ff;
   logic [4:0]  out_hr_ff;
   logic [2:0]  out_wd_ff;
   logic [11:0] out_year_ff;
   logic [3:0]  out_mon_ff;
   logic [4:0]  out_day_ff;
   logic        out_load;

   // shared unit
   alu_op_type  alu_op;
   logic [31:0] alu_opa;
   logic [31:0] alu_opb;
   alu_res_type alu_res;

   // per-division operands
   logic [31:0] div_x;
   logic [31:0] div_recip;
   logic [31:0] div_quo;
   logic [31:0] div_d;

   logic        leap;

   u2c_alu u_alu (
      .op  (alu_op),
      .opa (alu_opa),
      .opb (alu_opb),
      .res (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff   <= stg_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      prod_ff  <= prod_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hr_ff    <= hr_in;
      wd_ff    <= wd_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      ym100_ff <= ym100_in;
      ym400_ff <= ym400_in;
      mon_ff   <= mon_in;
      if (out_load) begin
         out_sec_ff  <= sec_ff;
         out_min_ff  <= min_ff;
         out_hr_ff   <= hr_ff;
         out_wd_ff   <= wd_ff;
         out_year_ff <= year_ff;
         out_mon_ff  <= mon_ff + 4'd1;
         out_day_ff  <= days_ff[4:0] + 5'd1;
      end
   end

   always_comb begin
      leap = (year_ff[1:0] == 2'd0) && ((ym100_ff != 7'd0) || (ym400_ff == 9'd0));

      // divide by 60 as a shift by 2 then by 15, by 24 as a shift by 3 then by 3
      div_x     = {2'd0, num_ff[31:2]};
      div_recip = RECIP_15;
      div_quo   = {3'd0, prod_ff[63:35]};
      div_d     = 32'(SEC_PER_MIN);
      case (stg_ff)
         STG_MIN: begin
            div_d = 32'(MIN_PER_HOUR);
         end
         STG_HOUR: begin
            div_x     = {3'd0, num_ff[31:3]};
            div_recip = RECIP_3;
            div_quo   = {1'd0, prod_ff[63:33]};
            div_d     = 32'(HOUR_PER_DAY);
         end
         STG_WDAY: begin
            div_x     = num_ff;
            div_recip = RECIP_7;
            div_quo   = prod_ff[63:32];
            div_d     = 32'(DAY_PER_WEEK);
         end
         default: begin
            // seconds keep the values above
         end
      endcase

      state_in  = state_ff;
      stg_in    = stg_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      prod_in   = prod_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hr_in     = hr_ff;
      wd_in     = wd_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      ym100_in  = ym100_ff;
      ym400_in  = ym400_ff;
      mon_in    = mon_ff;
      alu_op    = ALU_SUB;
      alu_opa   = 32'd0;
      alu_opb   = 32'd0;
      req_stall = 1'b1;
      out_load  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               num_in   = req_epoch_seconds;
               stg_in   = STG_SEC;
               state_in = ST_RECIP;
            end
         end
         ST_RECIP: begin
            // multiply by the reciprocal; the quotient sits in the high bits
            alu_op   = ALU_MUL;
            alu_opa  = div_x;
            alu_opb  = div_recip;
            prod_in  = alu_res.val;
            state_in = ST_BACK;
         end
         ST_BACK: begin
            // multiply the quotient back by the divisor
            alu_op   = ALU_MUL;
            alu_opa  = div_quo;
            alu_opb  = div_d;
            quo_in   = div_quo;
            prod_in  = alu_res.val;
            state_in = ST_REM;
         end
         ST_REM: begin
            // remainder is the dividend less quotient times divisor
            alu_op  = ALU_SUB;
            alu_opa = num_ff;
            alu_opb = prod_ff[31:0];
            case (stg_ff)
               STG_SEC: begin
                  sec_in   = alu_res.val[5:0];
                  num_in   = quo_ff;
                  stg_in   = STG_MIN;
                  state_in = ST_RECIP;
               end
               STG_MIN: begin
                  min_in   = alu_res.val[5:0];
                  num_in   = quo_ff;
                  stg_in   = STG_HOUR;
                  state_in = ST_RECIP;
               end
               STG_HOUR: begin
                  // the quotient is the whole-day count; offset it for the weekday
                  hr_in    = alu_res.val[4:0];
                  days_in  = quo_ff[15:0];
                  num_in   = quo_ff + {16'd0, EPOCH_WDAY_OFS};
                  stg_in   = STG_WDAY;
                  state_in = ST_RECIP;
               end
               STG_WDAY: begin
                  wd_in    = alu_res.val[2:0] + 3'd1;
                  year_in  = EPOCH_YEAR;
                  ym100_in = EPOCH_YEAR_100;
                  ym400_in = EPOCH_YEAR_400;
                  state_in = ST_YEAR;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_YEAR: begin
            // drop one whole year per pass while the day count covers it
            alu_op  = ALU_SUB;
            alu_opa = {16'd0, days_ff};
            alu_opb = {16'd0, (leap ? DAYS_LEAP_YEAR : DAYS_YEAR)};
            if (alu_res.ge) begin
               days_in  = alu_res.val[15:0];
               year_in  = year_ff + 12'd1;
               ym100_in = (ym100_ff == 7'd99)  ? 7'd0 : ym100_ff + 7'd1;
               ym400_in = (ym400_ff == 9'd399) ? 9'd0 : ym400_ff + 9'd1;
            end else begin
               mon_in   = 4'd0;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            alu_op  = ALU_SUB;
            alu_opa = {16'd0, days_ff};
            alu_opb = {27'd0, month_len(mon_ff, leap)};
            if (alu_res.ge) begin
               days_in = alu_res.val[15:0];
            end
            if (!alu_res.ge || (mon_ff == MONTH_LAST)) begin
               state_in = ST_LOAD;
            end else begin
               mon_in = mon_ff + 4'd1;
            end
         end
         ST_LOAD: begin
            // wait here while the previous result is still stalled
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_second_of_minute = out_sec_ff;
   assign rsp_minute_of_hour   = out_min_ff;
   assign rsp_hour_of_day      = out_hr_ff;
   assign rsp_weekday          = out_wd_ff;
   assign rsp_year_number      = out_year_ff;
   assign rsp_month_number     = out_mon_ff;
   assign rsp_day_of_month     = out_day_ff;

endmodule
